### sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, constants and helpers of the single-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned TW            = 10;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [TW-1:0] READ_TAIL_US = TW'(50);
  localparam logic [2:0]    BIT_LAST     = 3'(BITS_PER_BYTE - 1);

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WRITE_ONE_LOW = 3'd3,
    REG_WRITE_ZERO_LOW = 3'd4,
    REG_WRITE_SLOT    = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_RST_LOW  = 8'b0000_0010,
    PH_RST_WAIT = 8'b0000_0100,
    PH_RST_TAIL = 8'b0000_1000,
    PH_WR_SLOT  = 8'b0001_0000,
    PH_RD_LOW   = 8'b0010_0000,
    PH_RD_WAIT  = 8'b0100_0000,
    PH_RD_TAIL  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [TW-1:0] reset_low_us;
    logic [TW-1:0] presence_wait_us;
    logic [TW-1:0] reset_tail_us;
    logic [TW-1:0] write_one_low_us;
    logic [TW-1:0] write_zero_low_us;
    logic [TW-1:0] write_slot_us;
    logic [TW-1:0] read_low_us;
    logic [TW-1:0] read_sample_us;
  } cfg_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] wdata;
    logic       level;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

  function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

endpackage

### sv/owm_if.sv
// ----------------------------------------------------------------------------
// owm_in_if / owm_out_if
// Valid/ready channels carrying tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] func;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, cmd_valid, func, write_data, line_level, input ready);
  modport sink   (input valid, cmd_valid, func, write_data, line_level, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_data,
                  output ready);
endinterface

### sv/owm_cfg.sv
// ----------------------------------------------------------------------------
// owm_cfg
// APB-style register file holding the eight bus timing registers.
// ----------------------------------------------------------------------------
module owm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output owm_pkg::cfg_t              cfg
);

  logic [owm_pkg::TW-1:0] regs_r [owm_pkg::NUM_REGS];
  logic [2:0]             idx;
  logic                   wr_en;

  assign idx    = paddr[owm_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(32 - owm_pkg::TW){1'b0}}, regs_r[idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[owm_pkg::REG_RESET_LOW]      <= owm_pkg::TW'(480);
      regs_r[owm_pkg::REG_PRESENCE_WAIT]  <= owm_pkg::TW'(70);
      regs_r[owm_pkg::REG_RESET_TAIL]     <= owm_pkg::TW'(410);
      regs_r[owm_pkg::REG_WRITE_ONE_LOW]  <= owm_pkg::TW'(6);
      regs_r[owm_pkg::REG_WRITE_ZERO_LOW] <= owm_pkg::TW'(60);
      regs_r[owm_pkg::REG_WRITE_SLOT]     <= owm_pkg::TW'(70);
      regs_r[owm_pkg::REG_READ_LOW]       <= owm_pkg::TW'(2);
      regs_r[owm_pkg::REG_READ_SAMPLE]    <= owm_pkg::TW'(10);
    end else if (wr_en) begin
      regs_r[idx] <= pwdata[owm_pkg::TW-1:0];
    end
  end

  assign cfg.reset_low_us      = regs_r[owm_pkg::REG_RESET_LOW];
  assign cfg.presence_wait_us  = regs_r[owm_pkg::REG_PRESENCE_WAIT];
  assign cfg.reset_tail_us     = regs_r[owm_pkg::REG_RESET_TAIL];
  assign cfg.write_one_low_us  = regs_r[owm_pkg::REG_WRITE_ONE_LOW];
  assign cfg.write_zero_low_us = regs_r[owm_pkg::REG_WRITE_ZERO_LOW];
  assign cfg.write_slot_us     = regs_r[owm_pkg::REG_WRITE_SLOT];
  assign cfg.read_low_us       = regs_r[owm_pkg::REG_READ_LOW];
  assign cfg.read_sample_us    = regs_r[owm_pkg::REG_READ_SAMPLE];

endmodule

### sv/owm_queue.sv
// ----------------------------------------------------------------------------
// owm_queue
// Two-entry queue of classified tick beats between front and back.
// ----------------------------------------------------------------------------
module owm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  owm_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output owm_pkg::item_t head_item
);

  owm_pkg::item_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/owm_front.sv
// ----------------------------------------------------------------------------
// owm_front
// Accept tick beats, decode the command field and push them to the queue.
// ----------------------------------------------------------------------------
module owm_front (
  owm_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           push,
  output owm_pkg::item_t push_item
);

  always_comb begin
    push_item.start = 1'b0;
    push_item.op    = owm_pkg::OP_NONE;
    if (in_ch.cmd_valid) begin
      case (in_ch.func)
        owm_pkg::OP_RESET: begin
          push_item.start = 1'b1;
          push_item.op    = owm_pkg::OP_RESET;
        end
        owm_pkg::OP_WRITE: begin
          push_item.start = 1'b1;
          push_item.op    = owm_pkg::OP_WRITE;
        end
        owm_pkg::OP_READ: begin
          push_item.start = 1'b1;
          push_item.op    = owm_pkg::OP_READ;
        end
        default: begin
          push_item.start = 1'b0;
          push_item.op    = owm_pkg::OP_NONE;
        end
      endcase
    end
    push_item.wdata = in_ch.write_data;
    push_item.level = in_ch.line_level;
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

endmodule

### sv/owm_back.sv
// ----------------------------------------------------------------------------
// owm_back
// Bus sequencer: step one tick per beat and register the result beat.
// ----------------------------------------------------------------------------
module owm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  owm_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  owm_pkg::item_t head_item,
  output logic           pop,
  owm_out_if.source      out_ch
);

  owm_pkg::phase_t        phase_r, phase_nxt;
  logic [owm_pkg::TW-1:0] tick_r, tick_nxt;
  logic [2:0]             bidx_r, bidx_nxt;
  logic [7:0]             sb_r, sb_nxt;
  logic                   pres_r, pres_nxt;
  logic [7:0]             rdata_r, rdata_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic                   drive_r, busy_r, done_r;
  logic                   drive, busy, done;
  logic                   fire;

  assign fire = head_valid && (!ovalid_r || out_ch.ready);
  assign pop  = fire;

  always_comb begin
    owm_pkg::phase_t        ph;
    logic [owm_pkg::TW-1:0] tk;
    logic [2:0]             bi;
    logic [7:0]             sb;
    logic [owm_pkg::TW-1:0] len;
    logic [owm_pkg::TW-1:0] wr_len;
    logic [owm_pkg::TW-1:0] wr_low;
    logic                   last_bit;

    ph        = phase_r;
    tk        = tick_r;
    bi        = bidx_r;
    sb        = sb_r;
    pres_nxt  = pres_r;
    rdata_nxt = rdata_r;
    drive     = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;

    if (ph == owm_pkg::PH_IDLE && head_item.start) begin
      tk = '0;
      bi = '0;
      case (head_item.op)
        owm_pkg::OP_RESET: ph = owm_pkg::PH_RST_LOW;
        owm_pkg::OP_WRITE: begin
          ph = owm_pkg::PH_WR_SLOT;
          sb = head_item.wdata;
        end
        default: begin
          ph = owm_pkg::PH_RD_LOW;
          sb = '0;
        end
      endcase
    end

    wr_len = (cfg.write_slot_us < owm_pkg::TW'(2)) ? owm_pkg::TW'(2) : cfg.write_slot_us;
    wr_low = owm_pkg::at_least_one(sb[0] ? cfg.write_one_low_us : cfg.write_zero_low_us);
    if (wr_low > wr_len - owm_pkg::TW'(1)) begin
      wr_low = wr_len - owm_pkg::TW'(1);
    end
    last_bit = (bi == owm_pkg::BIT_LAST);

    case (ph)
      owm_pkg::PH_RST_LOW: begin
        len   = owm_pkg::at_least_one(cfg.reset_low_us);
        drive = 1'b1;
      end
      owm_pkg::PH_RST_WAIT: len = owm_pkg::at_least_one(cfg.presence_wait_us);
      owm_pkg::PH_RST_TAIL: len = owm_pkg::at_least_one(cfg.reset_tail_us);
      owm_pkg::PH_WR_SLOT: begin
        len   = wr_len;
        drive = (tk < wr_low);
      end
      owm_pkg::PH_RD_LOW: begin
        len   = owm_pkg::at_least_one(cfg.read_low_us);
        drive = 1'b1;
      end
      owm_pkg::PH_RD_WAIT: len = owm_pkg::at_least_one(cfg.read_sample_us);
      default:             len = owm_pkg::at_least_one(owm_pkg::READ_TAIL_US);
    endcase

    if (ph != owm_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (tk < len - owm_pkg::TW'(1)) begin
        tk = tk + owm_pkg::TW'(1);
      end else begin
        tk = '0;
        case (ph)
          owm_pkg::PH_RST_LOW: ph = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: begin
            pres_nxt = !head_item.level;
            if (cfg.reset_tail_us == '0) begin
              ph   = owm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              ph = owm_pkg::PH_RST_TAIL;
            end
          end
          owm_pkg::PH_RST_TAIL: begin
            ph   = owm_pkg::PH_IDLE;
            done = 1'b1;
          end
          owm_pkg::PH_WR_SLOT: begin
            sb = {1'b0, sb[7:1]};
            if (last_bit) begin
              ph   = owm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              bi = bi + 3'd1;
            end
          end
          owm_pkg::PH_RD_LOW: ph = owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_RD_WAIT: begin
            sb = {head_item.level, sb[7:1]};
            ph = owm_pkg::PH_RD_TAIL;
          end
          default: begin
            if (last_bit) begin
              rdata_nxt = sb;
              ph        = owm_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              bi = bi + 3'd1;
              ph = owm_pkg::PH_RD_LOW;
            end
          end
        endcase
        if (done) begin
          bi = '0;
        end
      end
    end

    phase_nxt  = ph;
    tick_nxt   = tk;
    bidx_nxt   = bi;
    sb_nxt     = sb;
    ovalid_nxt = fire ? 1'b1 : (ovalid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owm_pkg::PH_IDLE;
      tick_r   <= '0;
      bidx_r   <= '0;
      sb_r     <= '0;
      pres_r   <= 1'b0;
      rdata_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bidx_r  <= bidx_nxt;
        sb_r    <= sb_nxt;
        pres_r  <= pres_nxt;
        rdata_r <= rdata_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= drive;
      busy_r  <= busy;
      done_r  <= done;
    end
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.drive_low = drive_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.presence  = pres_r;
  assign out_ch.read_data = rdata_r;

endmodule

### sv/one_wire_bus_master.sv
// Path: an accepted tick beat is written into the queue; when it reaches the head and
//   the result register is empty or being taken, its result beat is registered there.
// Throughput: while result beats are taken, one tick beat per cycle passes through the
//   two-entry queue and registered result stage; sequencer steps one tick per cycle.
// Reset: timing registers return to their defaults, the queue empties, the
//   sequencer goes idle and presence and read data clear to zero.
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master: reset/presence, byte write and byte read sequencer.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic                       clk,
  input  logic                       rst_n,
  owm_in_if.sink                     in_ch,
  owm_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  owm_pkg::cfg_t  cfg;
  owm_pkg::item_t push_item;
  owm_pkg::item_t head_item;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           head_valid;

  owm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owm_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  owm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  owm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-wire bus master. Tick beats go in from a
// queue and a cycle-accurate predictor of the sequencer works out the result
// beat each tick must produce. Every result beat is compared field by field.
// The timing registers are read back at their defaults, then set over APB
// between phases while the master is idle: all zero, clamped write slots and
// small random settings; all at maximum is checked by readback.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] write_data;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } bus_res_t;

  typedef struct packed {
    owm_pkg::phase_t ph;
    logic [10:0]     ticks;
    logic [2:0]      bit_no;
    logic [7:0]      shreg;
    owm_pkg::op_t    op;
    logic            pres;
    logic [7:0]      rd_byte;
  } master_st_t;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_NOISE} line_mode_t;

  logic                       clk     = 1'b1;
  logic                       rst_n   = 1'b0;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [owm_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                pwdata  = '0;
  logic [31:0]                prdata;
  logic                       pready;

  owm_in_if  in_ch ();
  owm_out_if out_ch ();

  one_wire_bus_master u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  owm_pkg::cfg_t timing;
  master_st_t    plan_st;
  master_st_t    live_st;
  tick_t         ticks_to_send[$];
  bus_res_t      results_due[$];
  int unsigned   ticks_queued = 0;
  int unsigned   ticks_taken  = 0;
  int unsigned   beats_seen   = 0;
  int unsigned   mismatches   = 0;
  int unsigned   cycles       = 0;
  int unsigned   stall_pct    = 38;
  logic          tick_accepted = 1'b0;

  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  function automatic owm_pkg::cfg_t factory_timing();
    owm_pkg::cfg_t c;
    c.reset_low_us      = 10'd480;
    c.presence_wait_us  = 10'd70;
    c.reset_tail_us     = 10'd410;
    c.write_one_low_us  = 10'd6;
    c.write_zero_low_us = 10'd60;
    c.write_slot_us     = 10'd70;
    c.read_low_us       = 10'd2;
    c.read_sample_us    = 10'd10;
    return c;
  endfunction

  function automatic logic [owm_pkg::TW-1:0] reg_value(input owm_pkg::cfg_t c,
                                                       input owm_pkg::reg_idx_t idx);
    case (idx)
      owm_pkg::REG_RESET_LOW:      return c.reset_low_us;
      owm_pkg::REG_PRESENCE_WAIT:  return c.presence_wait_us;
      owm_pkg::REG_RESET_TAIL:     return c.reset_tail_us;
      owm_pkg::REG_WRITE_ONE_LOW:  return c.write_one_low_us;
      owm_pkg::REG_WRITE_ZERO_LOW: return c.write_zero_low_us;
      owm_pkg::REG_WRITE_SLOT:     return c.write_slot_us;
      owm_pkg::REG_READ_LOW:       return c.read_low_us;
      default:                     return c.read_sample_us;
    endcase
  endfunction

  function automatic master_st_t idle_master();
    master_st_t s;
    s = '0;
    s.ph = owm_pkg::PH_IDLE;
    s.op = owm_pkg::OP_RESET;
    return s;
  endfunction

  function automatic int unsigned floor1(input logic [owm_pkg::TW-1:0] v);
    return (v == '0) ? 1 : v;
  endfunction

  function automatic bus_res_t advance_master(inout master_st_t s, input tick_t t);
    bus_res_t    r;
    int unsigned span;
    int unsigned low;
    logic        last_bit;
    r = '0;
    if (s.ph == owm_pkg::PH_IDLE && t.cmd_valid && t.func != owm_pkg::OP_NONE) begin
      s.op     = owm_pkg::op_t'(t.func);
      s.ticks  = '0;
      s.bit_no = '0;
      case (t.func)
        owm_pkg::OP_RESET: s.ph = owm_pkg::PH_RST_LOW;
        owm_pkg::OP_WRITE: begin
          s.ph    = owm_pkg::PH_WR_SLOT;
          s.shreg = t.write_data;
        end
        default: begin
          s.ph    = owm_pkg::PH_RD_LOW;
          s.shreg = '0;
        end
      endcase
    end
    if (s.ph != owm_pkg::PH_IDLE) begin
      last_bit   = (s.bit_no == 3'(owm_pkg::BITS_PER_BYTE - 1));
      r.busy_res = 1'b1;
      case (s.ph)
        owm_pkg::PH_RST_LOW: begin
          span        = floor1(timing.reset_low_us);
          r.drive_low = 1'b1;
        end
        owm_pkg::PH_RST_WAIT: span = floor1(timing.presence_wait_us);
        owm_pkg::PH_RST_TAIL: span = floor1(timing.reset_tail_us);
        owm_pkg::PH_WR_SLOT: begin
          span = (timing.write_slot_us < 2) ? 2 : timing.write_slot_us;
          low  = floor1(s.shreg[0] ? timing.write_one_low_us : timing.write_zero_low_us);
          if (low > span - 1) low = span - 1;
          r.drive_low = (s.ticks < low);
        end
        owm_pkg::PH_RD_LOW: begin
          span        = floor1(timing.read_low_us);
          r.drive_low = 1'b1;
        end
        owm_pkg::PH_RD_WAIT: span = floor1(timing.read_sample_us);
        default:             span = floor1(owm_pkg::READ_TAIL_US);
      endcase
      if (s.ticks + 1 < span) begin
        s.ticks = s.ticks + 11'd1;
      end else begin
        s.ticks = '0;
        case (s.ph)
          owm_pkg::PH_RST_LOW: s.ph = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: begin
            s.pres = ~t.line_level;
            if (timing.reset_tail_us == '0) begin
              s.ph       = owm_pkg::PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              s.ph = owm_pkg::PH_RST_TAIL;
            end
          end
          owm_pkg::PH_RST_TAIL: begin
            s.ph       = owm_pkg::PH_IDLE;
            r.done_res = 1'b1;
          end
          owm_pkg::PH_WR_SLOT: begin
            s.shreg = s.shreg >> 1;
            if (last_bit) begin
              s.ph       = owm_pkg::PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              s.bit_no = s.bit_no + 3'd1;
            end
          end
          owm_pkg::PH_RD_LOW: s.ph = owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_RD_WAIT: begin
            s.shreg = {t.line_level, s.shreg[7:1]};
            s.ph    = owm_pkg::PH_RD_TAIL;
          end
          default: begin
            if (last_bit) begin
              s.rd_byte  = s.shreg;
              s.ph       = owm_pkg::PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              s.bit_no = s.bit_no + 3'd1;
              s.ph     = owm_pkg::PH_RD_LOW;
            end
          end
        endcase
        if (r.done_res) s.bit_no = '0;
      end
    end
    r.presence  = s.pres;
    r.read_data = s.rd_byte;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch cycle %0d beat %0d: %s", cycles, beats_seen, what);
  endtask

  // drive ticks at the falling edge, hold a beat until it is taken
  always @(negedge clk) begin
    tick_t nxt;
    if (rst_n) begin
      if (!in_ch.valid || tick_accepted) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= stall_pct) begin
          nxt = ticks_to_send.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.cmd_valid  <= nxt.cmd_valid;
          in_ch.func       <= nxt.func;
          in_ch.write_data <= nxt.write_data;
          in_ch.line_level <= nxt.line_level;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    tick_t    seen;
    bus_res_t want;
    cycles        <= cycles + 1;
    tick_accepted <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.cmd_valid  = in_ch.cmd_valid;
      seen.func       = in_ch.func;
      seen.write_data = in_ch.write_data;
      seen.line_level = in_ch.line_level;
      results_due.push_back(advance_master(live_st, seen));
      ticks_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (results_due.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = results_due.pop_front();
        if (out_ch.drive_low !== want.drive_low)
          note_mismatch($sformatf("drive_low %b want %b", out_ch.drive_low, want.drive_low));
        if (out_ch.busy_res !== want.busy_res)
          note_mismatch($sformatf("busy_res %b want %b", out_ch.busy_res, want.busy_res));
        if (out_ch.done_res !== want.done_res)
          note_mismatch($sformatf("done_res %b want %b", out_ch.done_res, want.done_res));
        if (out_ch.presence !== want.presence)
          note_mismatch($sformatf("presence %b want %b", out_ch.presence, want.presence));
        if (out_ch.read_data !== want.read_data)
          note_mismatch($sformatf("read_data %h want %h", out_ch.read_data, want.read_data));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic line_for(input line_mode_t mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom);
    endcase
  endfunction

  task automatic push_tick(input tick_t t);
    void'(advance_master(plan_st, t));
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  // one command beat, then ticks until the master is idle again
  task automatic issue_cmd(input owm_pkg::op_t op, input logic [7:0] data,
                           input line_mode_t mode, input int unsigned poke_pct);
    tick_t t;
    t.cmd_valid  = 1'b1;
    t.func       = op;
    t.write_data = data;
    t.line_level = line_for(mode);
    push_tick(t);
    while (plan_st.ph != owm_pkg::PH_IDLE) begin
      t.cmd_valid  = ($urandom_range(99) < poke_pct);
      t.func       = 2'($urandom);
      t.write_data = 8'($urandom);
      t.line_level = line_for(mode);
      push_tick(t);
    end
  endtask

  task automatic idle_gap(input int unsigned n);
    tick_t t;
    repeat (n) begin
      t.cmd_valid  = ($urandom_range(3) == 0);
      t.func       = t.cmd_valid ? owm_pkg::OP_NONE : 2'($urandom);
      t.write_data = 8'($urandom);
      t.line_level = 1'($urandom);
      push_tick(t);
    end
  endtask

  // resets, writes and ignored codes; a read costs hundreds of ticks
  task automatic random_commands(input int unsigned budget);
    int unsigned  start;
    int unsigned  pick;
    owm_pkg::op_t op;
    start = ticks_queued;
    while (ticks_queued - start < budget) begin
      pick = $urandom_range(19);
      op   = (pick == 0) ? owm_pkg::OP_NONE :
             ((pick % 2 == 0) ? owm_pkg::OP_WRITE : owm_pkg::OP_RESET);
      issue_cmd(op, 8'($urandom), LINE_NOISE, $urandom_range(30));
      idle_gap($urandom_range(3));
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_reg(input owm_pkg::reg_idx_t idx, input logic [owm_pkg::TW-1:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== 32'(want))
      note_mismatch($sformatf("register %s reads %h want %h", idx.name(), got, want));
  endtask

  task automatic check_defaults();
    for (int i = 0; i < owm_pkg::NUM_REGS; i++)
      check_reg(owm_pkg::reg_idx_t'(i), reg_value(timing, owm_pkg::reg_idx_t'(i)));
  endtask

  task automatic program_reg(input owm_pkg::reg_idx_t idx, input logic [owm_pkg::TW-1:0] val);
    logic [31:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {22'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[owm_pkg::TW-1:0] !== val)
      note_mismatch($sformatf("register %s reads %h want %h", idx.name(),
                              got[owm_pkg::TW-1:0], val));
    case (idx)
      owm_pkg::REG_RESET_LOW:      timing.reset_low_us      = val;
      owm_pkg::REG_PRESENCE_WAIT:  timing.presence_wait_us  = val;
      owm_pkg::REG_RESET_TAIL:     timing.reset_tail_us     = val;
      owm_pkg::REG_WRITE_ONE_LOW:  timing.write_one_low_us  = val;
      owm_pkg::REG_WRITE_ZERO_LOW: timing.write_zero_low_us = val;
      owm_pkg::REG_WRITE_SLOT:     timing.write_slot_us     = val;
      owm_pkg::REG_READ_LOW:       timing.read_low_us       = val;
      default:                     timing.read_sample_us    = val;
    endcase
  endtask

  task automatic program_all(input logic [owm_pkg::TW-1:0] val);
    for (int i = 0; i < owm_pkg::NUM_REGS; i++) program_reg(owm_pkg::reg_idx_t'(i), val);
  endtask

  task automatic shuffle_timing(input int unsigned hi);
    for (int i = 0; i < owm_pkg::NUM_REGS; i++)
      program_reg(owm_pkg::reg_idx_t'(i), owm_pkg::TW'($urandom_range(hi)));
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd_valid  = 1'b0;
    in_ch.func       = owm_pkg::OP_RESET;
    in_ch.write_data = '0;
    in_ch.line_level = 1'b1;
    out_ch.ready     = 1'b0;
    timing  = factory_timing();
    plan_st = idle_master();
    live_st = idle_master();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_defaults();
    issue_cmd(owm_pkg::OP_NONE, 8'h00, LINE_HIGH, 0);
    drain();

    program_all('0);
    issue_cmd(owm_pkg::OP_RESET, 8'h00, LINE_LOW, 0);
    issue_cmd(owm_pkg::OP_RESET, 8'hFF, LINE_HIGH, 100);
    issue_cmd(owm_pkg::OP_WRITE, 8'hFF, LINE_HIGH, 0);
    issue_cmd(owm_pkg::OP_WRITE, 8'h00, LINE_LOW, 100);
    issue_cmd(owm_pkg::OP_WRITE, 8'h5A, LINE_NOISE, 25);
    drain();

    program_reg(owm_pkg::REG_WRITE_SLOT, 10'd1);
    program_reg(owm_pkg::REG_WRITE_ONE_LOW, 10'd1023);
    issue_cmd(owm_pkg::OP_WRITE, 8'h96, LINE_NOISE, 0);
    drain();
    program_reg(owm_pkg::REG_WRITE_SLOT, 10'd3);
    program_reg(owm_pkg::REG_WRITE_ZERO_LOW, 10'd7);
    random_commands(60);
    drain();

    // long stretch with no idling on either side
    stall_pct = 0;
    shuffle_timing(7);
    issue_cmd(owm_pkg::OP_READ, 8'h00, LINE_NOISE, 25);
    random_commands(150);
    drain();
    stall_pct = 38;

    shuffle_timing(12);
    random_commands(250);
    drain();

    program_all(10'd1023);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
